FILE: sv/csfd_pkg.sv
// package for the can signal field decoder: config types, register indexes, widths
`timescale 1ns / 1ps

package csfd_pkg;

    localparam int DATA_W  = 64;
    localparam int BYTES_W = 4;
    localparam int START_W = 6;
    localparam int LEN_W   = 7;
    localparam int GAIN_W  = 32;
    localparam int BIAS_W  = 64;
    localparam int IDX_W   = 3;
    localparam int SUM_W   = 98;   // 65 x 32 product plus 64-bit bias

    localparam logic [BYTES_W-1:0] MAX_BYTES = 4'd8;
    localparam logic [LEN_W-1:0]   MAX_LEN   = 7'd64;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_FIELD_START  = 3'd0,
        REG_FIELD_LENGTH = 3'd1,
        REG_LITTLE_ORDER = 3'd2,
        REG_SIGNED_FIELD = 3'd3,
        REG_GAIN_Q16     = 3'd4,
        REG_BIAS_Q16     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [START_W-1:0]       field_start;
        logic [LEN_W-1:0]         field_length;
        logic                     little_order;
        logic                     signed_field;
        logic signed [GAIN_W-1:0] gain_q16;
        logic signed [BIAS_W-1:0] bias_q16;
    } t_cfg;

endpackage

FILE: sv/can_signal_field_decoder.sv
// top level of the can signal field decoder
`timescale 1ns / 1ps
// usage:
//   a request is taken at the clock edge where i_start is high and o_busy is low;
//   o_busy stays low, the pipeline never stalls, so a new frame can come every cycle
//   i_payload holds up to eight bytes (byte i in bits 8i+7..8i), i_payload_bytes
//   the valid count; bytes at or past the count read as zero, counts above 8 mean 8
//   one result per request: o_valid is high for exactly one cycle with
//   o_phys_value, o_raw_field and o_clipped; the receiver cannot hold it off
//   pipeline registers, in order, from the accepting edge to the result:
//   input register, field extraction, two 33x32 partial products, 98-bit sum,
//   saturation into the output register; throughput one frame per cycle
//   configuration: i_cfg_we writes register i_cfg_idx with i_cfg_wdata at once;
//   indexes past the bias register are ignored; write only while nothing is in flight
//   reset (i_rst_n low, synchronous) empties the pipeline and loads the
//   register defaults: start 0, length 8, little layout, unsigned, gain 1.0, bias 0

module can_signal_field_decoder import csfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [DATA_W-1:0]        i_payload,
    input  logic [BYTES_W-1:0]       i_payload_bytes,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_wdata,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_phys_value,
    output logic [DATA_W-1:0]        o_raw_field,
    output logic                     o_clipped
);

    t_cfg                cfg;
    logic                load;
    logic                x_valid;
    logic [DATA_W-1:0]   x_raw;
    logic [DATA_W:0]     x_sval;

    // fully pipelined, every request is taken
    assign o_busy = 1'b0;
    assign load   = i_start && !o_busy;

    csfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register, then field pick and sign extension
    csfd_extract u_extract (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_payload       (i_payload),
        .i_payload_bytes (i_payload_bytes),
        .i_cfg           (cfg),
        .o_valid         (x_valid),
        .o_raw           (x_raw),
        .o_sval          (x_sval)
    );

    // gain multiply in two halves, bias add, saturation to 64 bits
    csfd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (x_valid),
        .i_raw        (x_raw),
        .i_sval       (x_sval),
        .i_cfg        (cfg),
        .o_valid      (o_valid),
        .o_phys_value (o_phys_value),
        .o_raw_field  (o_raw_field),
        .o_clipped    (o_clipped)
    );

endmodule

FILE: sv/csfd_cfg_regs.sv
// configuration register file of the can signal field decoder
`timescale 1ns / 1ps

module csfd_cfg_regs import csfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [DATA_W-1:0]   i_cfg_wdata,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIELD_START:  n_cfg.field_start  = i_cfg_wdata[START_W-1:0];
                REG_FIELD_LENGTH: n_cfg.field_length = i_cfg_wdata[LEN_W-1:0];
                REG_LITTLE_ORDER: n_cfg.little_order = i_cfg_wdata[0];
                REG_SIGNED_FIELD: n_cfg.signed_field = i_cfg_wdata[0];
                REG_GAIN_Q16:     n_cfg.gain_q16     = i_cfg_wdata[GAIN_W-1:0];
                REG_BIAS_Q16:     n_cfg.bias_q16     = i_cfg_wdata[BIAS_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_start  <= '0;
            r_cfg.field_length <= 7'd8;
            r_cfg.little_order <= 1'b1;
            r_cfg.signed_field <= 1'b0;
            r_cfg.gain_q16     <= 32'sd65536;
            r_cfg.bias_q16     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/csfd_extract.sv
// input register and bit field extraction stage
`timescale 1ns / 1ps

module csfd_extract import csfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [DATA_W-1:0]    i_payload,
    input  logic [BYTES_W-1:0]   i_payload_bytes,
    input  t_cfg                 i_cfg,
    output logic                 o_valid,
    output logic [DATA_W-1:0]    o_raw,
    output logic [DATA_W:0]      o_sval
);

    logic                 r_in_valid;
    logic [DATA_W-1:0]    r_payload;
    logic [BYTES_W-1:0]   r_bytes;
    logic                 r_valid;
    logic [DATA_W-1:0]    r_raw;
    logic [DATA_W:0]      r_sval;

    logic [BYTES_W-1:0]   nbytes;
    logic [DATA_W-1:0]    data;
    logic [DATA_W-1:0]    swapped;
    logic [LEN_W-1:0]     len;
    logic [DATA_W-1:0]    len_mask;
    logic [START_W-1:0]   top;
    logic [7:0]           be_shift;
    logic [2*DATA_W-1:0]  be_wide;
    logic [DATA_W-1:0]    le_bits;
    logic [DATA_W-1:0]    n_raw;
    logic [START_W-1:0]   msb_pos;
    logic                 neg;
    logic [DATA_W:0]      n_sval;

    always_comb begin
        nbytes = (r_bytes > MAX_BYTES) ? MAX_BYTES : r_bytes;
        for (int i = 0; i < 8; i++) begin
            data[8*i +: 8]          = (4'(i) < nbytes) ? r_payload[8*i +: 8] : 8'h00;
            swapped[8*(7-i) +: 8]   = data[8*i +: 8];
        end

        len      = (i_cfg.field_length > MAX_LEN) ? MAX_LEN : i_cfg.field_length;
        len_mask = (len == MAX_LEN) ? '1 : ((64'd1 << len) - 64'd1);

        // little layout: start is the lsb, field runs upward
        le_bits = data >> i_cfg.field_start;

        // big layout: byte swap puts the walk order msb-first, start is the field msb
        top      = {~i_cfg.field_start[5:3], i_cfg.field_start[2:0]};
        be_shift = 8'd65 + {2'b00, top} - {1'b0, len};
        be_wide  = {swapped, 64'd0} >> be_shift;

        n_raw   = (i_cfg.little_order ? le_bits : be_wide[DATA_W-1:0]) & len_mask;
        msb_pos = START_W'(len - 7'd1);
        neg     = i_cfg.signed_field && (len != '0) && n_raw[msb_pos];
        n_sval  = {neg, n_raw | (neg ? ~len_mask : 64'd0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_in_valid <= i_load;
            r_valid    <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_payload <= i_payload;
            r_bytes   <= i_payload_bytes;
        end
        r_raw  <= n_raw;
        r_sval <= n_sval;
    end

    assign o_valid = r_valid;
    assign o_raw   = r_raw;
    assign o_sval  = r_sval;

endmodule

FILE: sv/csfd_scale.sv
// scale, offset and saturation stages
`timescale 1ns / 1ps

module csfd_scale import csfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [DATA_W-1:0]        i_raw,
    input  logic [DATA_W:0]          i_sval,
    input  t_cfg                     i_cfg,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_phys_value,
    output logic [DATA_W-1:0]        o_raw_field,
    output logic                     o_clipped
);

    // partial products: low 32 bits as unsigned, upper 33 bits signed
    logic                     r_m_valid;
    logic signed [DATA_W:0]   r_prod_lo;
    logic signed [DATA_W:0]   r_prod_hi;
    logic [DATA_W-1:0]        r_m_raw;
    logic                     r_s_valid;
    logic signed [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0]        r_s_raw;
    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_phys;
    logic [DATA_W-1:0]        r_o_raw;
    logic                     r_clip;

    logic signed [DATA_W:0]   n_prod_lo;
    logic signed [DATA_W:0]   n_prod_hi;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     fits;
    logic signed [DATA_W-1:0] n_phys;

    always_comb begin
        n_prod_lo = $signed({1'b0, i_sval[31:0]}) * i_cfg.gain_q16;
        n_prod_hi = $signed(i_sval[DATA_W:32]) * i_cfg.gain_q16;

        n_sum = ({{(SUM_W-DATA_W-1){r_prod_hi[DATA_W]}}, r_prod_hi} <<< 32)
              + {{(SUM_W-DATA_W-1){r_prod_lo[DATA_W]}}, r_prod_lo}
              + {{(SUM_W-BIAS_W){i_cfg.bias_q16[BIAS_W-1]}}, i_cfg.bias_q16};

        fits   = (r_sum[SUM_W-1:DATA_W-1] == '0) || (r_sum[SUM_W-1:DATA_W-1] == '1);
        n_phys = fits ? r_sum[DATA_W-1:0]
                      : (r_sum[SUM_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
            r_s_valid <= r_m_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_lo <= n_prod_lo;
        r_prod_hi <= n_prod_hi;
        r_m_raw   <= i_raw;
        r_sum     <= n_sum;
        r_s_raw   <= r_m_raw;
        r_phys    <= n_phys;
        r_o_raw   <= r_s_raw;
        r_clip    <= !fits;
    end

    assign o_valid      = r_o_valid;
    assign o_phys_value = r_phys;
    assign o_raw_field  = r_o_raw;
    assign o_clipped    = r_clip;

endmodule

FILE: verif/field_decode_checker.sv
// checker for the can signal field decoder: watches requests, register writes and results, predicts and compares
`timescale 1ns / 1ps

module field_decode_checker import csfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [DATA_W-1:0]        i_payload,
    input  logic [BYTES_W-1:0]       i_payload_bytes,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_wdata,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_phys_value,
    input  logic [DATA_W-1:0]        i_raw_field,
    input  logic                     i_clipped,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] phys_value;
        logic [DATA_W-1:0] raw_field;
        logic              clipped;
    } t_field_result;

    t_cfg          field_cfg;
    t_field_result expected_fields[$];

    function automatic t_field_result decode_frame(input t_cfg cfg,
                                                   input logic [DATA_W-1:0] payload,
                                                   input logic [BYTES_W-1:0] nbytes);
        t_field_result     res;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] sval;
        logic signed [127:0] a_w;
        logic signed [127:0] g_w;
        logic signed [127:0] sum_w;
        int unsigned nb;
        int unsigned len;
        int unsigned pos;
        int unsigned byte_i;
        int unsigned bit_i;
        nb = (nbytes > MAX_BYTES) ? 8 : nbytes;
        data = payload;
        if (nb < 8)
            data = payload & ((64'd1 << (nb * 8)) - 64'd1);
        len = (cfg.field_length > MAX_LEN) ? 64 : cfg.field_length;
        mask = (len >= 64) ? {DATA_W{1'b1}} : ((64'd1 << len) - 64'd1);

        raw = '0;
        if (cfg.little_order) begin
            // start bit is the lsb, walk upward
            for (int unsigned k = 0; k < len; k++) begin
                pos = cfg.field_start + k;
                if (pos < 64)
                    raw[k] = data[pos];
            end
        end else begin
            // start bit is the msb, walk down and wrap to bit 7 of the next byte
            byte_i = cfg.field_start >> 3;
            bit_i  = cfg.field_start & 7;
            for (int unsigned k = 0; k < len; k++) begin
                raw = {raw[DATA_W-2:0], (byte_i < 8) ? data[byte_i * 8 + bit_i] : 1'b0};
                if (bit_i == 0) begin
                    bit_i  = 7;
                    byte_i = byte_i + 1;
                end else begin
                    bit_i = bit_i - 1;
                end
            end
        end
        raw = raw & mask;

        sval = raw;
        if (cfg.signed_field && len > 0) begin
            if (raw[len - 1])
                sval = raw | ~mask;
        end

        a_w = cfg.signed_field ? {{64{sval[63]}}, sval} : {64'd0, sval};
        g_w = {{96{cfg.gain_q16[GAIN_W-1]}}, cfg.gain_q16};
        sum_w = a_w * g_w + {{64{cfg.bias_q16[BIAS_W-1]}}, cfg.bias_q16};

        res.raw_field = raw;
        if (sum_w[127:64] == {64{sum_w[63]}}) begin
            res.phys_value = sum_w[63:0];
            res.clipped    = 1'b0;
        end else begin
            res.phys_value = sum_w[127] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
            res.clipped    = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_field_result got;
        t_field_result want;
        if (!i_rst_n) begin
            field_cfg.field_start  = '0;
            field_cfg.field_length = 7'd8;
            field_cfg.little_order = 1'b1;
            field_cfg.signed_field = 1'b0;
            field_cfg.gain_q16     = 32'sd65536;
            field_cfg.bias_q16     = '0;
            expected_fields.delete();
        end else begin
            // predict with the settings in force before any write at this edge
            if (i_start && !i_busy)
                expected_fields.insert(expected_fields.size(),
                                       decode_frame(field_cfg, i_payload, i_payload_bytes));

            if (i_valid) begin
                got.phys_value = i_phys_value;
                got.raw_field  = i_raw_field;
                got.clipped    = i_clipped;
                if (expected_fields.size() == 0) begin
                    $error("result with no request pending: phys_value %h raw_field %h",
                           got.phys_value, got.raw_field);
                    o_fail_count++;
                end else begin
                    want = expected_fields.pop_front();
                    if (got.phys_value !== want.phys_value) begin
                        $error("phys_value: expected %h, got %h", want.phys_value, got.phys_value);
                        o_fail_count++;
                    end
                    if (got.raw_field !== want.raw_field) begin
                        $error("raw_field: expected %h, got %h", want.raw_field, got.raw_field);
                        o_fail_count++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
                        o_fail_count++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FIELD_START:  field_cfg.field_start  = i_cfg_wdata[START_W-1:0];
                    REG_FIELD_LENGTH: field_cfg.field_length = i_cfg_wdata[LEN_W-1:0];
                    REG_LITTLE_ORDER: field_cfg.little_order = i_cfg_wdata[0];
                    REG_SIGNED_FIELD: field_cfg.signed_field = i_cfg_wdata[0];
                    REG_GAIN_Q16:     field_cfg.gain_q16     = i_cfg_wdata[GAIN_W-1:0];
                    REG_BIAS_Q16:     field_cfg.bias_q16     = i_cfg_wdata[BIAS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_fields.size();
    end

endmodule

FILE: verif/tb.sv
// testbench top for the can signal field decoder: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb;
    import csfd_pkg::*;

    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PHASES    = 14;
    localparam int FRAMES_PER_PHASE = 50;
    localparam int SETTLE_CYCLES    = 10;   // pipeline is five deep, leave some margin

    // index past the bias register, the block must ignore it
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] POS_MAX  = {1'b0, {63{1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN  = {1'b1, {63{1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h0001_0000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [DATA_W-1:0]        i_payload;
    logic [BYTES_W-1:0]       i_payload_bytes;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_idx;
    logic [DATA_W-1:0]        i_cfg_wdata;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_phys_value;
    logic [DATA_W-1:0]        o_raw_field;
    logic                     o_clipped;

    int fail_count;
    int pending;
    int idle_cycles;
    int burst_left;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    can_signal_field_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_payload       (i_payload),
        .i_payload_bytes (i_payload_bytes),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_phys_value    (o_phys_value),
        .o_raw_field     (o_raw_field),
        .o_clipped       (o_clipped)
    );

    field_decode_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_payload       (i_payload),
        .i_payload_bytes (i_payload_bytes),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (o_valid),
        .i_phys_value    (o_phys_value),
        .i_raw_field     (o_raw_field),
        .i_clipped       (o_clipped),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // watchdog: any request, result or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // present one request and hold it until taken; the sender works in bursts,
    // and a gap of zero keeps start high straight into the next request
    task automatic send_frame(input logic [DATA_W-1:0] payload,
                              input logic [BYTES_W-1:0] nbytes);
        int gap;
        i_start         <= 1'b1;
        i_payload       <= payload;
        i_payload_bytes <= nbytes;
        do @(posedge i_clk); while (o_busy);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // every request gives a result, so an empty expectation store means idle
    task automatic drain_pipeline();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // idle the block, then write all six registers; bits above each register's
    // width carry junk that must be dropped
    task automatic apply_settings(input logic [START_W-1:0] start,
                                  input logic [LEN_W-1:0] len,
                                  input logic little,
                                  input logic sign_ext,
                                  input logic [GAIN_W-1:0] gain,
                                  input logic [BIAS_W-1:0] bias);
        logic [DATA_W-1:0] junk;
        drain_pipeline();
        junk = rand64();
        set_reg(REG_FIELD_START,  {junk[DATA_W-1:START_W], start});
        set_reg(REG_FIELD_LENGTH, {junk[DATA_W-1:LEN_W], len});
        set_reg(REG_LITTLE_ORDER, {junk[DATA_W-1:1], little});
        set_reg(REG_SIGNED_FIELD, {junk[DATA_W-1:1], sign_ext});
        set_reg(REG_GAIN_Q16,     {junk[DATA_W-1:GAIN_W], gain});
        set_reg(REG_BIAS_Q16,     bias);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [START_W-1:0] r_start;
        logic [LEN_W-1:0]   r_len;
        logic [GAIN_W-1:0]  r_gain;
        logic [BIAS_W-1:0]  r_bias;
        logic [DATA_W-1:0]  r_payload;
        logic [BYTES_W-1:0] r_bytes;

        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_payload       = '0;
        i_payload_bytes = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        burst_left      = $urandom_range(1, 10);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: byte 0, unsigned, gain 1.0, byte count zero and above eight
        send_frame(64'h0123_4567_89AB_CDEF, 4'd8);
        send_frame(ALL_ONES, 4'd0);
        send_frame(64'hFEDC_BA98_7654_3210, 4'd15);

        // full width signed field, largest gain and bias: clips both ways
        apply_settings(6'd0, 7'd64, 1'b1, 1'b1, GAIN_MAX, POS_MAX);
        send_frame(ALL_ONES, 4'd8);
        send_frame(POS_MAX, 4'd8);
        send_frame(NEG_MIN, 4'd8);

        // empty field: result is the bias alone
        apply_settings(6'd60, 7'd0, 1'b0, 1'b1, GAIN_MIN, NEG_MIN);
        send_frame(ALL_ONES, 4'd8);
        send_frame(64'h5555_5555_5555_5555, 4'd9);

        // big layout over the whole frame, length above 64 saturates
        apply_settings(6'd7, 7'd127, 1'b0, 1'b0, GAIN_MIN, '0);
        send_frame(ALL_ONES, 4'd8);
        send_frame(64'h0123_4567_89AB_CDEF, 4'd4);

        // big layout running off the end of the frame
        apply_settings(6'd58, 7'd20, 1'b0, 1'b1, GAIN_ONE, ALL_ONES);
        send_frame(ALL_ONES, 4'd8);
        send_frame(64'hAAAA_AAAA_AAAA_AAAA, 4'd8);

        // little layout running off the end, negative gain, last byte not valid
        apply_settings(6'd62, 7'd10, 1'b1, 1'b0, 32'hFFFF_0000, '0);
        send_frame(ALL_ONES, 4'd8);
        send_frame(64'hC000_0000_0000_0000, 4'd7);

        // big layout starting mid byte, zero gain
        apply_settings(6'd13, 7'd12, 1'b0, 1'b1, '0, 64'h1234);
        send_frame(64'h0000_0000_0000_3F80, 4'd2);
        send_frame(ALL_ONES, 4'd1);

        // random phases: fresh settings each time, then a run of requests
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            r_start = START_W'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0:       r_len = '0;
                1:       r_len = MAX_LEN;
                2:       r_len = LEN_W'($urandom_range(65, 127));
                default: r_len = LEN_W'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 5))
                0:       r_gain = GAIN_MAX;
                1:       r_gain = GAIN_MIN;
                2:       r_gain = GAIN_ONE;
                3:       r_gain = $urandom_range(0, 8) * GAIN_ONE - 4 * GAIN_ONE;
                default: r_gain = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       r_bias = POS_MAX;
                1:       r_bias = NEG_MIN;
                2:       r_bias = '0;
                3:       r_bias = {{32{1'b0}}, $urandom} - 64'h8000_0000;
                default: r_bias = rand64();
            endcase
            apply_settings(r_start, r_len, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), r_gain, r_bias);
            if (phase == 3) begin
                @(posedge i_clk);
                set_reg(REG_UNUSED, rand64());
                i_cfg_we <= 1'b0;
            end

            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0:       r_payload = '0;
                    1:       r_payload = ALL_ONES;
                    2:       r_payload = 64'd1 << $urandom_range(0, 63);
                    default: r_payload = rand64();
                endcase
                r_bytes = ($urandom_range(0, 3) == 0) ? BYTES_W'($urandom_range(0, 15))
                                                      : MAX_BYTES;
                send_frame(r_payload, r_bytes);
            end
        end

        // let the last results come out, then allow for anything stray
        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
